// ===== design/aabb_point_pushout_assert.svh =====
// Assertion macros for the aabb_point_pushout checker.
// Expects clk and rst_n in the scope of use.
`ifndef AABB_POINT_PUSHOUT_ASSERT_SVH
`define AABB_POINT_PUSHOUT_ASSERT_SVH

// same-cycle implication
`define AABB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aabb_point_pushout: same-cycle check failed");

// next-cycle implication
`define AABB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aabb_point_pushout: next-cycle check failed");

`endif

// ===== design/aabb_pkg.sv =====
// Shared types, register codes, constants and helpers for aabb_point_pushout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

    localparam logic [16:0] PUSH_FACTOR = 17'd68813;   // 1.05 in Q16.16

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5,
        REG_FRICTION = 3'd6,
        REG_MARGIN   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        FACE_XN = 3'd0,
        FACE_XP = 3'd1,
        FACE_YN = 3'd2,
        FACE_YP = 3'd3,
        FACE_ZN = 3'd4,
        FACE_ZP = 3'd5
    } face_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [29:0] half_x;
        logic        [29:0] half_y;
        logic        [29:0] half_z;
        logic        [16:0] friction;
        logic        [29:0] margin;
    } box_cfg_t;

    localparam logic signed [31:0] RST_CENTER_X = 32'sd327680;
    localparam logic signed [31:0] RST_CENTER_Y = 32'sd0;
    localparam logic signed [31:0] RST_CENTER_Z = -32'sd196608;
    localparam logic        [29:0] RST_HALF     = 30'd131072;
    localparam logic        [16:0] RST_FRICTION = 17'd65536;
    localparam logic        [29:0] RST_MARGIN   = 30'd9830;

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x > SAT_MAX)
            return 32'sh7fffffff;
        else if (x < SAT_MIN)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/aabb_dist.sv =====
// Widened-box inside test and the six absolute face distances.
// Uses aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aabb_dist
    import aabb_pkg::*;
(
    input  logic signed [31:0] pos [3],
    input  logic signed [31:0] ctr [3],
    input  logic        [29:0] half [3],
    input  logic        [29:0] margin,
    output logic               in_box,
    output logic        [31:0] face_dist [6]
);

    logic signed [34:0] pe  [3];
    logic signed [34:0] lo  [3];
    logic signed [34:0] hi  [3];
    logic signed [34:0] dlo [3];
    logic signed [34:0] dhi [3];
    logic signed [34:0] mw;
    logic        [2:0]  in_ax;

    always_comb
    begin
        mw = $signed(35'(margin));
        for (int a = 0; a < 3; a++)
        begin
            pe[a]  = 35'(pos[a]);
            lo[a]  = 35'(ctr[a]) - $signed(35'(half[a]));
            hi[a]  = 35'(ctr[a]) + $signed(35'(half[a]));
            in_ax[a] = (pe[a] > lo[a] - mw) && (pe[a] < hi[a] + mw);
            dlo[a] = pe[a] - lo[a];
            dhi[a] = hi[a] - pe[a];
            if (dlo[a][34])
                dlo[a] = -dlo[a];
            if (dhi[a][34])
                dhi[a] = -dhi[a];
            // inside the widened box both distances stay below 2^32
            face_dist[2*a]   = dlo[a][31:0];
            face_dist[2*a+1] = dhi[a][31:0];
        end
        in_box = &in_ax;
    end

endmodule

`default_nettype wire

// ===== design/aabb_fsel.sv =====
// Nearest-face selection over six distances, lowest face index wins ties.
// Uses aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aabb_fsel
    import aabb_pkg::*;
(
    input  logic [31:0] face_dist [6],
    output face_t       face,
    output logic [31:0] best
);

    logic [31:0] d0, d1, d2, dm;
    face_t       f0, f1, f2, fm;

    // right operand is always the earlier face, so strict < keeps it on a tie
    always_comb
    begin
        d0 = (face_dist[1] < face_dist[0]) ? face_dist[1] : face_dist[0];
        f0 = (face_dist[1] < face_dist[0]) ? FACE_XP : FACE_XN;
        d1 = (face_dist[3] < face_dist[2]) ? face_dist[3] : face_dist[2];
        f1 = (face_dist[3] < face_dist[2]) ? FACE_YP : FACE_YN;
        d2 = (face_dist[5] < face_dist[4]) ? face_dist[5] : face_dist[4];
        f2 = (face_dist[5] < face_dist[4]) ? FACE_ZP : FACE_ZN;
        dm = (d1 < d0) ? d1 : d0;
        fm = (d1 < d0) ? f1 : f0;
        best = (d2 < dm) ? d2 : dm;
        face = (d2 < dm) ? f2 : fm;
    end

endmodule

`default_nettype wire

// ===== design/aabb_scale.sv =====
// Push distance (x1.05) and friction scaling, both floored to Q16.16.
// Uses aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aabb_scale
    import aabb_pkg::*;
(
    input  logic        [31:0] best,
    input  logic signed [31:0] vel [3],
    input  logic        [16:0] friction,
    output logic        [32:0] push,
    output logic signed [32:0] vel_scaled [3]
);

    logic        [48:0] push_prod;
    logic signed [49:0] vprod [3];

    always_comb
    begin
        push_prod = 49'(best) * 49'(PUSH_FACTOR);
        push      = push_prod[48:16];
        for (int a = 0; a < 3; a++)
        begin
            vprod[a]      = 50'(vel[a]) * $signed(50'(friction));
            // arithmetic shift floors toward minus infinity
            vel_scaled[a] = vprod[a][48:16];
        end
    end

endmodule

`default_nettype wire

// ===== design/aabb_point_pushout.sv =====
// aabb_point_pushout: pushes a cloth node out of an axis-aligned box.
// Five register stages: input, distance, face select, multiply and result.
// Throughput: one word per cycle; each stage advances on its own when the next is free.
// Reset: clears all stage valids and loads the box registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module aabb_point_pushout
    import aabb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    // hit, face
    output logic [3:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    box_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= RST_CENTER_X;
            cfg_reg.center_y <= RST_CENTER_Y;
            cfg_reg.center_z <= RST_CENTER_Z;
            cfg_reg.half_x   <= RST_HALF;
            cfg_reg.half_y   <= RST_HALF;
            cfg_reg.half_z   <= RST_HALF;
            cfg_reg.friction <= RST_FRICTION;
            cfg_reg.margin   <= RST_MARGIN;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_CENTER_X: cfg_reg.center_x <= cfg_wdata;
                REG_CENTER_Y: cfg_reg.center_y <= cfg_wdata;
                REG_CENTER_Z: cfg_reg.center_z <= cfg_wdata;
                REG_HALF_X:   cfg_reg.half_x   <= cfg_wdata[29:0];
                REG_HALF_Y:   cfg_reg.half_y   <= cfg_wdata[29:0];
                REG_HALF_Z:   cfg_reg.half_z   <= cfg_wdata[29:0];
                REG_FRICTION: cfg_reg.friction <= cfg_wdata[16:0];
                REG_MARGIN:   cfg_reg.margin   <= cfg_wdata[29:0];
            endcase
        end
    end

    logic signed [31:0] ctr  [3];
    logic        [29:0] half [3];

    assign ctr[0]  = cfg_reg.center_x;
    assign ctr[1]  = cfg_reg.center_y;
    assign ctr[2]  = cfg_reg.center_z;
    assign half[0] = cfg_reg.half_x;
    assign half[1] = cfg_reg.half_y;
    assign half[2] = cfg_reg.half_z;

    // stage flow control
    logic [4:0] vld_reg, vld_next, rdy;

    always_comb
    begin
        rdy[4] = !vld_reg[4] || m_tready;
        for (int k = 3; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < 5; k++)
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[4];

    // stage payloads
    logic signed [31:0] p0_reg [3], v0_reg [3];
    logic signed [31:0] p1_reg [3], v1_reg [3];
    logic               in1_reg;
    logic        [31:0] d1_reg [6];
    logic signed [31:0] p2_reg [3], v2_reg [3];
    logic               in2_reg;
    face_t              face2_reg;
    logic        [31:0] bd2_reg;
    logic signed [31:0] p3_reg [3], v3_reg [3];
    logic               in3_reg;
    face_t              face3_reg;
    logic        [32:0] push3_reg;
    logic signed [32:0] vs3_reg [3];
    logic signed [31:0] op_reg [3], ov_reg [3];
    logic               hit_reg;
    face_t              face_reg;

    logic               in_box;
    logic        [31:0] face_dist [6];
    face_t              face_sel;
    logic        [31:0] best;
    logic        [32:0] push;
    logic signed [32:0] vel_scaled [3];
    logic signed [31:0] op_next [3], ov_next [3];
    logic               hit_next;
    face_t              face_next;

    aabb_dist u_dist (
        .pos       (p0_reg),
        .ctr       (ctr),
        .half      (half),
        .margin    (cfg_reg.margin),
        .in_box    (in_box),
        .face_dist (face_dist)
    );

    aabb_fsel u_fsel (
        .face_dist (d1_reg),
        .face      (face_sel),
        .best      (best)
    );

    aabb_scale u_scale (
        .best       (bd2_reg),
        .vel        (v2_reg),
        .friction   (cfg_reg.friction),
        .push       (push),
        .vel_scaled (vel_scaled)
    );

    logic signed [34:0] sum;

    always_comb
    begin
        sum = '0;
        for (int a = 0; a < 3; a++)
        begin
            if (in3_reg)
            begin
                if (face3_reg[2:1] == 2'(a))
                    sum = face3_reg[0] ? 35'(p3_reg[a]) + $signed(35'(push3_reg))
                                       : 35'(p3_reg[a]) - $signed(35'(push3_reg));
                else
                    sum = 35'(p3_reg[a]);
                op_next[a] = sat32(sum);
                ov_next[a] = sat32(35'(vs3_reg[a]));
            end
            else
            begin
                op_next[a] = p3_reg[a];
                ov_next[a] = v3_reg[a];
            end
        end
        hit_next  = in3_reg;
        face_next = in3_reg ? face3_reg : FACE_XN;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_tvalid)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p0_reg[a] <= s_tdata[32*a +: 32];
                v0_reg[a] <= s_tdata[96 + 32*a +: 32];
            end
        end
        if (rdy[1] && vld_reg[0])
        begin
            p1_reg  <= p0_reg;
            v1_reg  <= v0_reg;
            in1_reg <= in_box;
            d1_reg  <= face_dist;
        end
        if (rdy[2] && vld_reg[1])
        begin
            p2_reg    <= p1_reg;
            v2_reg    <= v1_reg;
            in2_reg   <= in1_reg;
            face2_reg <= face_sel;
            bd2_reg   <= best;
        end
        if (rdy[3] && vld_reg[2])
        begin
            p3_reg    <= p2_reg;
            v3_reg    <= v2_reg;
            in3_reg   <= in2_reg;
            face3_reg <= face2_reg;
            push3_reg <= push;
            vs3_reg   <= vel_scaled;
        end
        if (rdy[4] && vld_reg[3])
        begin
            op_reg   <= op_next;
            ov_reg   <= ov_next;
            hit_reg  <= hit_next;
            face_reg <= face_next;
        end
    end

    assign m_tdata = {ov_reg[2], ov_reg[1], ov_reg[0], op_reg[2], op_reg[1], op_reg[0]};
    assign m_tuser = {face_reg, hit_reg};

endmodule

`default_nettype wire

// ===== design/aabb_chk.sv =====
// Port-level checker for aabb_point_pushout, attached by bind.
// Uses aabb_pkg and aabb_point_pushout_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "aabb_point_pushout_assert.svh"

module aabb_chk
    import aabb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tready,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [191:0] m_tdata,
    input  wire logic [3:0]   m_tuser
);

    // stalled result word holds
    `AABB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // a miss always reports face zero
    `AABB_ASSERT_IMP(a_miss_face, m_tvalid && !m_tuser[0], m_tuser[3:1] == FACE_XN)

    // face code stays within the six faces
    `AABB_ASSERT_IMP(a_face_range, m_tvalid, m_tuser[3:1] <= FACE_ZP)

    // an empty output register means the pipe can take a word
    `AABB_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)

endmodule

bind aabb_point_pushout aabb_chk u_chk (.*);

`default_nettype wire
